// ===== hw/rtl/ctd_pkg.sv =====
package ctd_pkg;

    localparam int CHANNELS = 8;
    localparam int WINDOW   = 10;

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WDEPTH  = CHANNELS * WINDOW;
    localparam int WA_W    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

    localparam int SAMPLE_W = 10;
    localparam int SUM_W    = $clog2(WINDOW * 1023 + 1);
    localparam int FAC_W    = 12;
    localparam int FSC_W    = FAC_W + $clog2(WINDOW + 1);
    localparam int PROD_W   = SAMPLE_W + FSC_W;
    localparam int LHS_W    = SUM_W + 8;
    localparam int CMP_W    = (PROD_W > LHS_W) ? PROD_W : LHS_W;
    localparam int CNT_W    = 8;
    localparam int ACT_W    = 4;
    localparam int TOT_W    = 14;
    localparam int SAT_W    = SUM_W + TOT_W;
    localparam int TOT_MAX  = 2 ** TOT_W - 1;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [1:0] MODE_CAL  = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_EVAL = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [1:0] REG_ON_FACTOR  = 2'd0;
    localparam logic [1:0] REG_OFF_FACTOR = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE   = 2'd2;
    localparam logic [1:0] REG_ACTIVE     = 2'd3;

    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic [SAMPLE_W-1:0] base;
        logic                on;
        logic [CNT_W-1:0]    cnt;
    } t_chan;

    typedef struct packed {
        logic [1:0]          mode;
        logic                ok;
        logic [SAMPLE_W-1:0] sample;
        logic                start;
        logic [CH_W-1:0]     ch;
        logic [WA_W-1:0]     waddr;
    } t_req;

    typedef struct packed {
        logic [FSC_W-1:0] on_sc;
        logic [FSC_W-1:0] off_sc;
        logic [CNT_W-1:0] limit;
    } t_cfg;

    typedef struct packed {
        logic chan_we;
        logic win_we;
    } t_wen;

    typedef struct packed {
        logic                triggered;
        logic                channel_ok;
        logic [SAMPLE_W-1:0] baseline;
        logic [TOT_W-1:0]    window_total;
    } t_res;

    function automatic logic [TOT_W-1:0] sat_total(input logic [SUM_W-1:0] s);
        logic [SAT_W-1:0] w;
        w = SAT_W'(s);
        if (w > SAT_W'(TOT_MAX)) begin
            return TOT_W'(TOT_MAX);
        end
        return w[TOT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/ctd_ram.sv =====
module ctd_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_q;
    logic             r_q_vld;
    logic             r_hit;
    logic [WIDTH-1:0] r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q   <= r_mem[i_raddr];
            r_fwd <= i_wdata;
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_q_vld <= r_vld[i_raddr];
                r_hit   <= i_we && (i_waddr == i_raddr);
            end
        end
    end

    assign o_rdata = r_hit ? r_fwd : (r_q_vld ? r_q : '0);

endmodule

// ===== hw/rtl/ctd_eval.sv =====
module ctd_eval (
    input  ctd_pkg::t_req                  i_req,
    input  ctd_pkg::t_chan                 i_chan,
    input  logic [ctd_pkg::SAMPLE_W-1:0]   i_old,
    input  ctd_pkg::t_cfg                  i_cfg,
    output ctd_pkg::t_chan                 o_chan,
    output ctd_pkg::t_wen                  o_wen,
    output ctd_pkg::t_res                  o_res
);
    import ctd_pkg::*;

    logic [FSC_W-1:0]  factor;
    logic [PROD_W-1:0] rhs;
    logic [LHS_W-1:0]  lhs;
    logic              want;
    logic [CNT_W-1:0]  cnt_inc;
    t_chan             nxt;

    assign factor  = i_chan.on ? i_cfg.off_sc : i_cfg.on_sc;
    assign rhs     = PROD_W'(i_chan.base) * PROD_W'(factor);
    assign lhs     = {i_chan.sum, 8'b0};
    assign want    = CMP_W'(lhs) > CMP_W'(rhs);
    assign cnt_inc = i_chan.cnt + 1'b1;

    always_comb begin
        nxt = i_chan;
        case (i_req.mode)
            MODE_CAL: begin
                if (i_req.start || (i_req.sample > i_chan.base)) begin
                    nxt.base = i_req.sample;
                end
            end
            MODE_READ: begin
                nxt.sum = i_chan.sum - SUM_W'(i_old) + SUM_W'(i_req.sample);
            end
            MODE_EVAL: begin
                if (want == i_chan.on) begin
                    nxt.cnt = '0;
                end else if (cnt_inc >= i_cfg.limit) begin
                    nxt.on  = want;
                    nxt.cnt = '0;
                end else begin
                    nxt.cnt = cnt_inc;
                end
            end
            default: begin
                nxt = i_chan;
            end
        endcase
    end

    assign o_chan        = nxt;
    assign o_wen.chan_we = i_req.ok && (i_req.mode != MODE_NONE);
    assign o_wen.win_we  = i_req.ok && (i_req.mode == MODE_READ);

    always_comb begin
        if (i_req.ok) begin
            o_res.triggered    = nxt.on;
            o_res.channel_ok   = 1'b1;
            o_res.baseline     = nxt.base;
            o_res.window_total = sat_total(nxt.sum);
        end else begin
            o_res = '0;
        end
    end

endmodule

// ===== hw/rtl/current_trigger_detector_unit.sv =====
// channel   signals                                              direction
// request   i_in_valid, o_in_stall, i_mode, i_channel, i_sample,  in
//           i_start_calibration
// result    o_out_valid, i_out_stall, o_triggered, o_channel_ok,  out
//           o_baseline, o_window_total
// config    psel, penable, pwrite, paddr, pwdata, prdata, pready  APB
//
// One request per cycle while o_in_stall is low. Its result is registered.
// Channel state and the window ring sit in registered-read RAMs read at accept
// and written back from the request stage; same-entry back-to-back hits are
// forwarded. Reset is synchronous; RAM contents read as zero until written
// (valid bits). An output stall freezes the pipeline and raises o_in_stall.
module current_trigger_detector_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_mode,
    input  logic [2:0]                   i_channel,
    input  logic [ctd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                         i_start_calibration,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_triggered,
    output logic                         o_channel_ok,
    output logic [ctd_pkg::SAMPLE_W-1:0] o_baseline,
    output logic [ctd_pkg::TOT_W-1:0]    o_window_total,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ctd_pkg::PADDR_W-1:0]  paddr,
    input  logic [ctd_pkg::PDATA_W-1:0]  pwdata,
    output logic [ctd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import ctd_pkg::*;

    localparam logic [4:0]      CH_LIM = 5'(CHANNELS);
    localparam logic [WA_W-1:0] WIN_A  = WA_W'(WINDOW);

    logic [FAC_W-1:0] r_on_factor;
    logic [FAC_W-1:0] r_off_factor;
    logic [CNT_W-1:0] r_limit;
    logic [ACT_W-1:0] r_active;
    logic [FSC_W-1:0] r_on_sc;
    logic [FSC_W-1:0] r_off_sc;
    logic             cfg_wr;
    logic [1:0]       cfg_idx;

    logic [PTR_W-1:0] r_ptr [CHANNELS];

    logic             advance;
    logic             accept;
    logic             in_ok;
    logic [CH_W-1:0]  in_ch;
    logic [PTR_W-1:0] cur_ptr;
    logic [WA_W-1:0]  in_waddr;

    logic             r_b_valid;
    t_req             r_b_req;
    t_req             n_b_req;

    t_chan            rd_chan;
    logic [SAMPLE_W-1:0] rd_old;
    t_chan            wb_chan;
    t_wen             wen;
    t_res             res;
    t_cfg             cfg;
    logic             chan_we;
    logic             win_we;

    logic             r_out_valid;
    t_res             r_res;

    // configuration
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_factor  <= FAC_W'(384);
            r_off_factor <= FAC_W'(320);
            r_limit      <= CNT_W'(3);
            r_active     <= ACT_W'(8);
            r_on_sc      <= FSC_W'(384 * WINDOW);
            r_off_sc     <= FSC_W'(320 * WINDOW);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ON_FACTOR: begin
                    r_on_factor <= pwdata[FAC_W-1:0];
                    r_on_sc     <= FSC_W'(pwdata[FAC_W-1:0]) * FSC_W'(WINDOW);
                end
                REG_OFF_FACTOR: begin
                    r_off_factor <= pwdata[FAC_W-1:0];
                    r_off_sc     <= FSC_W'(pwdata[FAC_W-1:0]) * FSC_W'(WINDOW);
                end
                REG_DEBOUNCE: begin
                    r_limit <= pwdata[CNT_W-1:0];
                end
                REG_ACTIVE: begin
                    r_active <= pwdata[ACT_W-1:0];
                end
                default: begin
                    r_limit <= r_limit;
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ON_FACTOR:  prdata = PDATA_W'(r_on_factor);
            REG_OFF_FACTOR: prdata = PDATA_W'(r_off_factor);
            REG_DEBOUNCE:   prdata = PDATA_W'(r_limit);
            REG_ACTIVE:     prdata = PDATA_W'(r_active);
            default:        prdata = '0;
        endcase
    end

    assign cfg.on_sc  = r_on_sc;
    assign cfg.off_sc = r_off_sc;
    assign cfg.limit  = r_limit;

    // request stage
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = !advance;
    assign accept     = i_in_valid && advance;

    assign in_ok    = ({1'b0, i_channel} < r_active) && ({2'b0, i_channel} < CH_LIM);
    assign in_ch    = CH_W'(i_channel);
    assign cur_ptr  = r_ptr[in_ch];
    assign in_waddr = WA_W'(i_channel) * WIN_A + WA_W'(cur_ptr);

    always_comb begin
        n_b_req.mode   = i_mode;
        n_b_req.ok     = in_ok;
        n_b_req.sample = i_sample;
        n_b_req.start  = i_start_calibration;
        n_b_req.ch     = in_ch;
        n_b_req.waddr  = in_waddr;
    end

    // write pointers advance at accept, so the next request sees them at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_ptr[i] <= '0;
            end
        end else if (accept && in_ok && (i_mode == MODE_READ)) begin
            if (cur_ptr == PTR_W'(WINDOW - 1)) begin
                r_ptr[in_ch] <= '0;
            end else begin
                r_ptr[in_ch] <= cur_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (advance) begin
            r_b_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_req <= n_b_req;
        end
    end

    // state memories
    assign chan_we = r_b_valid && advance && wen.chan_we;
    assign win_we  = r_b_valid && advance && wen.win_we;

    ctd_ram #(
        .DEPTH (CHANNELS),
        .WIDTH ($bits(t_chan))
    ) u_chan_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (accept),
        .i_raddr (in_ch),
        .i_we    (chan_we),
        .i_waddr (r_b_req.ch),
        .i_wdata (wb_chan),
        .o_rdata (rd_chan)
    );

    ctd_ram #(
        .DEPTH (WDEPTH),
        .WIDTH (SAMPLE_W)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (accept),
        .i_raddr (in_waddr),
        .i_we    (win_we),
        .i_waddr (r_b_req.waddr),
        .i_wdata (r_b_req.sample),
        .o_rdata (rd_old)
    );

    ctd_eval u_eval (
        .i_req  (r_b_req),
        .i_chan (rd_chan),
        .i_old  (rd_old),
        .i_cfg  (cfg),
        .o_chan (wb_chan),
        .o_wen  (wen),
        .o_res  (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_b_valid) begin
            r_res <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_triggered    = r_res.triggered;
    assign o_channel_ok   = r_res.channel_ok;
    assign o_baseline     = r_res.baseline;
    assign o_window_total = r_res.window_total;

endmodule

// ===== sim/current_trigger_detector_unit_tb.sv =====
`timescale 1ns / 100ps

module current_trigger_detector_unit_tb;
    import ctd_pkg::*;

    localparam int         HOLD_CYCLES = 80;
    localparam int         PHASE_ITEMS = 200;

    logic                i_clk               = 1'b0;
    logic                i_rst_n             = 1'b0;
    logic                i_in_valid          = 1'b0;
    logic                o_in_stall;
    logic [1:0]          i_mode              = '0;
    logic [2:0]          i_channel           = '0;
    logic [SAMPLE_W-1:0] i_sample            = '0;
    logic                i_start_calibration = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall         = 1'b0;
    logic                o_triggered;
    logic                o_channel_ok;
    logic [SAMPLE_W-1:0] o_baseline;
    logic [TOT_W-1:0]    o_window_total;
    logic                psel                = 1'b0;
    logic                penable             = 1'b0;
    logic                pwrite              = 1'b0;
    logic [PADDR_W-1:0]  paddr               = '0;
    logic [PDATA_W-1:0]  pwdata              = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    current_trigger_detector_unit u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_mode              (i_mode),
        .i_channel           (i_channel),
        .i_sample            (i_sample),
        .i_start_calibration (i_start_calibration),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_triggered         (o_triggered),
        .o_channel_ok        (o_channel_ok),
        .o_baseline          (o_baseline),
        .o_window_total      (o_window_total),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [FAC_W-1:0]    cfg_on_factor  = 12'd384;
    logic [FAC_W-1:0]    cfg_off_factor = 12'd320;
    logic [CNT_W-1:0]    cfg_debounce   = 8'd3;
    logic [ACT_W-1:0]    cfg_active     = 4'd8;
    logic [SAMPLE_W-1:0] win_ring [CHANNELS][WINDOW];
    logic [SUM_W-1:0]    ring_sum [CHANNELS];
    int unsigned         ring_ptr [CHANNELS];
    logic [SAMPLE_W-1:0] base_max [CHANNELS];
    logic                trig_on  [CHANNELS];
    logic [CNT_W-1:0]    dis_count[CHANNELS];

    t_res        pending_results[$];
    int unsigned mismatch_count = 0;
    int unsigned sent_count     = 0;
    bit          tx_idle_en     = 1'b1;
    bit          rx_idle_en     = 1'b1;
    bit          hold_request   = 1'b0;

    function automatic t_res qualify_request(input logic [1:0] mode, input logic [2:0] ch,
                                             input logic [SAMPLE_W-1:0] smp,
                                             input logic start);
        t_res            r;
        int unsigned     p;
        logic            want;
        longint unsigned lhs;
        longint unsigned rhs;
        longint unsigned fac;
        r = '0;
        if (32'(ch) >= 32'(cfg_active) || 32'(ch) >= CHANNELS) return r;
        case (mode)
            MODE_CAL: begin
                if (start || smp > base_max[ch]) base_max[ch] = smp;
            end
            MODE_READ: begin
                p = (ring_ptr[ch] >= WINDOW) ? 0 : ring_ptr[ch];
                ring_sum[ch] = ring_sum[ch] - win_ring[ch][p] + smp;
                win_ring[ch][p] = smp;
                ring_ptr[ch] = (p + 1 >= WINDOW) ? 0 : p + 1;
            end
            MODE_EVAL: begin
                fac  = trig_on[ch] ? cfg_off_factor : cfg_on_factor;
                lhs  = longint'(ring_sum[ch]) << 8;
                rhs  = longint'(base_max[ch]) * fac * WINDOW;
                want = lhs > rhs;
                if (want == trig_on[ch]) begin
                    dis_count[ch] = '0;
                end else begin
                    dis_count[ch] = dis_count[ch] + 1'b1;
                    if (dis_count[ch] >= cfg_debounce) begin
                        trig_on[ch]   = want;
                        dis_count[ch] = '0;
                    end
                end
            end
            default: ;
        endcase
        r.triggered    = trig_on[ch];
        r.channel_ok   = 1'b1;
        r.baseline     = base_max[ch];
        r.window_total = (32'(ring_sum[ch]) > TOT_MAX) ? TOT_W'(TOT_MAX) : TOT_W'(ring_sum[ch]);
        return r;
    endfunction

    task automatic send_request(input logic [1:0] mode, input logic [2:0] ch,
                                input logic [SAMPLE_W-1:0] smp, input logic start);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_mode              <= mode;
        i_channel           <= ch;
        i_sample            <= smp;
        i_start_calibration <= start;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(qualify_request(mode, ch, smp, start));
        sent_count++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ON_FACTOR:  cfg_on_factor  = value[FAC_W-1:0];
            REG_OFF_FACTOR: cfg_off_factor = value[FAC_W-1:0];
            REG_DEBOUNCE:   cfg_debounce   = value[CNT_W-1:0];
            REG_ACTIVE:     cfg_active     = value[ACT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int unsigned on_f, input int unsigned off_f,
                                  input int unsigned deb, input int unsigned act);
        wait_drained();
        cfg_write(REG_ON_FACTOR, on_f);
        cfg_write(REG_OFF_FACTOR, off_f);
        cfg_write(REG_DEBOUNCE, deb);
        cfg_write(REG_ACTIVE, act);
    endtask

    // one short well-formed sequence on a channel, or a noise request
    task automatic send_burst();
        logic [2:0]   ch;
        int unsigned  kind;
        int unsigned  n;
        int unsigned  level;
        int           s;
        if ($urandom_range(0, 99) < 85)
            ch = 3'($urandom_range(0, cfg_active - 1));
        else
            ch = 3'($urandom_range(0, 7));
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 3) == 0) s = $urandom_range(0, 1023);
                else s = $urandom_range(0, 400);
                send_request(MODE_CAL, ch, SAMPLE_W'(s), (k == 0) && ($urandom_range(0, 1) == 1));
            end
        end else if (kind < 7) begin
            level = $urandom_range(0, 1023);
            n = $urandom_range(1, 10);
            for (int k = 0; k < n; k++) begin
                s = int'(level) + int'($urandom_range(0, 64)) - 32;
                if (s < 0) s = 0;
                if (s > 1023) s = 1023;
                send_request(MODE_READ, ch, SAMPLE_W'(s), 1'($urandom));
            end
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
                send_request(MODE_EVAL, ch, SAMPLE_W'($urandom), 1'($urandom));
        end else if (kind < 9) begin
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++)
                send_request(MODE_EVAL, ch, SAMPLE_W'($urandom), 1'($urandom));
        end else begin
            send_request(2'($urandom), 3'($urandom), SAMPLE_W'($urandom), 1'($urandom));
        end
    endtask

    task automatic send_bursts(input int unsigned count);
        int unsigned stop_at;
        stop_at = sent_count + count;
        while (sent_count < stop_at) send_burst();
    endtask

    task automatic test_directed();
        send_request(MODE_CAL, 3'd0, 10'd100, 1'b1);
        send_request(MODE_CAL, 3'd0, 10'd50, 1'b0);
        send_request(MODE_CAL, 3'd0, 10'd1023, 1'b0);
        send_request(MODE_CAL, 3'd0, 10'd0, 1'b1);
        send_request(MODE_CAL, 3'd0, 10'd100, 1'b1);
        repeat (4) send_request(MODE_READ, 3'd0, 10'd1023, 1'b0);
        repeat (3) send_request(MODE_EVAL, 3'd0, 10'd0, 1'b0);
        send_request(MODE_NONE, 3'd0, 10'd1023, 1'b1);
        send_request(MODE_READ, 3'd7, 10'd0, 1'b1);
        send_request(MODE_READ, 3'd7, 10'd1023, 1'b0);
        send_request(MODE_EVAL, 3'd7, 10'd1023, 1'b1);
        send_request(MODE_CAL, 3'd7, 10'd1023, 1'b1);
        send_request(MODE_EVAL, 3'd7, 10'd0, 1'b0);
    endtask

    task automatic test_register_extremes();
        // zero debounce limit, single active channel
        apply_settings(0, 4095, 0, 1);
        send_request(MODE_EVAL, 3'd1, 10'd0, 1'b0);
        send_request(MODE_CAL, 3'd7, 10'd1023, 1'b1);
        send_request(MODE_EVAL, 3'd0, 10'd0, 1'b0);
        send_bursts(25);
        apply_settings(4095, 0, 255, 8);
        send_bursts(25);
        apply_settings(4095, 4095, 1, 4);
        send_bursts(25);
        apply_settings(0, 0, 2, 1);
        send_bursts(25);
        apply_settings(384, 320, 1, 8);
        send_bursts(25);
    endtask

    task automatic test_backpressure();
        tx_idle_en   = 1'b0;
        hold_request = 1'b1;
        send_bursts(40);
        tx_idle_en   = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned on_f;
        for (int ph = 0; ph < 8; ph++) begin
            on_f = $urandom_range(200, 600);
            apply_settings(on_f, $urandom_range(150, on_f), $urandom_range(1, 4),
                           ($urandom_range(0, 1) == 1) ? 8 : $urandom_range(1, 8));
            tx_idle_en = (ph < 6);
            rx_idle_en = (ph < 6);
            send_bursts(PHASE_ITEMS);
        end
    endtask

    // result receiver: random stall bursts plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic report_field(input string name, input int unsigned exp_v,
                                input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no pending request, actual trig %0d ok %0d base %0d total %0d",
                         $time, o_triggered, o_channel_ok, o_baseline, o_window_total);
                mismatch_count++;
            end else begin
                want_r = pending_results.pop_front();
                report_field("triggered", want_r.triggered, o_triggered);
                report_field("channel_ok", want_r.channel_ok, o_channel_ok);
                report_field("baseline", want_r.baseline, o_baseline);
                report_field("window_total", want_r.window_total, o_window_total);
            end
        end
    end

    initial begin
        for (int c = 0; c < CHANNELS; c++) begin
            for (int w = 0; w < WINDOW; w++) win_ring[c][w] = '0;
            ring_sum[c]  = '0;
            ring_ptr[c]  = 0;
            base_max[c]  = '0;
            trig_on[c]   = 1'b0;
            dis_count[c] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== current_trigger_detector_unit.f =====
hw/rtl/ctd_pkg.sv
hw/rtl/ctd_ram.sv
hw/rtl/ctd_eval.sv
hw/rtl/current_trigger_detector_unit.sv
sim/current_trigger_detector_unit_tb.sv
